// ----- src/rcmc_pkg.sv -----
package rcmc_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 1024;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned VcntW       = VtxW + 1;
  localparam int unsigned EidxW       = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned CntW        = $clog2(MaxEdges + 1);
  localparam int unsigned CutW        = 11;
  localparam int unsigned RejectLimit = 64;
  localparam int unsigned TryW        = $clog2(RejectLimit);
  localparam logic [31:0] LfsrTaps    = 32'h8020_0003;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned EdgeW       = 2 * VtxW;

  localparam logic [VcntW-1:0] VcountReset = VcntW'(MaxVertices);
  localparam logic [31:0]      SeedReset   = 32'd1;

  // register index codes
  localparam logic RegVcount = 1'b0;
  localparam logic RegSeed   = 1'b1;

  typedef struct packed {
    logic [5:0] edge_from;
    logic [5:0] edge_to;
    logic       last_edge;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cut_size;
    logic        disconnected;
    logic        edges_dropped;
  } out_word_t;

  typedef struct packed {
    logic [VtxW-1:0] from_v;
    logic [VtxW-1:0] to_v;
  } edge_t;

  typedef struct packed {
    logic             hit;
    logic [EidxW-1:0] idx;
  } draw_res_t;

  // set every bit at or below the highest set bit
  function automatic logic [EidxW-1:0] smear_mask(input logic [EidxW-1:0] v);
    logic [EidxW-1:0] res;
    for (int i = 0; i < EidxW; i++) begin
      res[i] = |(v >> i);
    end
    return res;
  endfunction

endpackage

// ----- src/random_contraction_min_cut_unit.sv -----
// Edge words load one per cycle into a 1024-entry edge memory. The word
// flagged last_edge starts one contraction trial; no word is accepted until
// its result has been handed to the output register. Each contraction runs
// a check, draw steps until an index lands in range or the reject limit is
// hit, a step to latch the drawn edge, and one pass over the held edges
// through the single memory read port; a trial repeats this once per group
// merged, then ends with a final check and a step that loads the result.
// A result waiting at the output does not block loading of the next graph.
module random_contraction_min_cut_unit
  import rcmc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DRAW, S_PICK, S_SCAN, S_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  held_q, j_q, k_q;
  logic [VcntW-1:0] groups_q, vcount_q;
  logic [31:0]      seed_q;
  logic             drop_q, disc_q, pend_q, out_valid_q;
  out_word_t        out_q;
  logic [VtxW-1:0]  a_q, b_q;

  logic             cfg_wr, accept, bad, self_loop;
  logic [VcntW-1:0] nv;
  logic             we;
  logic [EidxW-1:0] waddr, raddr;
  edge_t            wdata, rdata, merged;
  draw_res_t        draw;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign prdata      = (paddr[2] == RegSeed) ? seed_q : 32'(vcount_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign nv        = (vcount_q > VcntW'(MaxVertices)) ? VcntW'(MaxVertices) : vcount_q;
  assign self_loop = in_data_i.edge_from == in_data_i.edge_to;
  assign bad       = (VcntW'(in_data_i.edge_from) >= nv) || (VcntW'(in_data_i.edge_to) >= nv)
                  || (held_q >= CntW'(MaxEdges));

  // relabel b to a on the edge coming back from the scan read
  assign merged.from_v = (rdata.from_v == b_q) ? a_q : rdata.from_v;
  assign merged.to_v   = (rdata.to_v == b_q) ? a_q : rdata.to_v;

  always_comb begin
    we    = 1'b0;
    waddr = k_q[EidxW-1:0];
    wdata = merged;
    if (state_q == S_IDLE) begin
      we          = accept && !self_loop && !bad;
      waddr       = held_q[EidxW-1:0];
      wdata.from_v = in_data_i.edge_from;
      wdata.to_v   = in_data_i.edge_to;
    end else if (state_q == S_SCAN) begin
      we = pend_q && (merged.from_v != merged.to_v);
    end
    raddr = (state_q == S_DRAW) ? draw.idx : j_q[EidxW-1:0];
  end

  rcmc_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rcmc_draw u_draw (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(cfg_wr && (paddr[2] == RegSeed)),
    .seed_i(pwdata),
    .step_i(state_q == S_DRAW),
    .n_i   (held_q),
    .res_o (draw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
      seed_q   <= SeedReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegVcount: vcount_q <= pwdata[VcntW-1:0];
        RegSeed:   seed_q   <= pwdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      groups_q    <= '0;
      drop_q      <= 1'b0;
      disc_q      <= 1'b0;
      pend_q      <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!self_loop) begin
              if (bad) begin
                drop_q <= 1'b1;
              end else begin
                held_q <= held_q + CntW'(1);
              end
            end
            if (in_data_i.last_edge) begin
              groups_q <= nv;
              disc_q   <= 1'b0;
              state_q  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (groups_q > VcntW'(2)) begin
            if (held_q == '0) begin
              disc_q  <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_DRAW;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DRAW: begin
          if (draw.hit) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          a_q     <= rdata.from_v;
          b_q     <= rdata.to_v;
          j_q     <= '0;
          k_q     <= '0;
          pend_q  <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // issue read j while writing back the word whose read was issued in the previous cycle
          if (j_q < held_q) begin
            j_q    <= j_q + CntW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q && (merged.from_v != merged.to_v)) begin
            k_q <= k_q + CntW'(1);
          end
          if ((j_q == held_q) && !pend_q) begin
            held_q   <= k_q;
            groups_q <= groups_q - VcntW'(1);
            state_q  <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.cut_size      <= disc_q ? '0 : CutW'(held_q);
            out_q.disconnected  <= disc_q;
            out_q.edges_dropped <= drop_q;
            held_q              <= '0;
            drop_q              <= 1'b0;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rcmc_ram.sv -----
module rcmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/rcmc_draw.sv -----
module rcmc_draw
  import rcmc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [31:0]     seed_i,
  input  logic            step_i,
  input  logic [CntW-1:0] n_i,
  output draw_res_t       res_o
);

  logic [31:0]      lfsr_q, lfsr_d;
  logic [TryW-1:0]  tries_q;
  logic [EidxW-1:0] mask;
  logic [EidxW-1:0] r;
  logic [CntW-1:0]  nm1;
  logic             in_range;

  assign lfsr_d   = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : 32'd0);
  assign nm1      = n_i - CntW'(1);
  assign mask     = smear_mask(nm1[EidxW-1:0]);
  assign r        = lfsr_d[EidxW-1:0] & mask;
  assign in_range = CntW'(r) < n_i;

  always_comb begin
    res_o.hit = in_range || (tries_q == TryW'(RejectLimit - 1));
    // after too many rejects fold the last draw back into range
    res_o.idx = in_range ? r : EidxW'(CntW'(r) - n_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q  <= SeedReset;
      tries_q <= '0;
    end else if (load_i) begin
      lfsr_q  <= (seed_i != 32'd0) ? seed_i : 32'd1;
      tries_q <= '0;
    end else if (step_i) begin
      lfsr_q  <= lfsr_d;
      tries_q <= res_o.hit ? '0 : tries_q + TryW'(1);
    end
  end

endmodule

// ----- src/rcmc_checker.sv -----
module rcmc_checker
  import rcmc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disconnected |-> out_data_o.cut_size == '0)
    else $error("disconnected trial reports nonzero cut");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cut_size <= CutW'(MaxEdges))
    else $error("cut size above edge capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_edge |=> !in_ready_o)
    else $error("input not stalled during trial");

endmodule

bind random_contraction_min_cut_unit rcmc_checker u_rcmc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
